// ===== design/rfu_pkg.sv =====
`timescale 1ns / 1ps

package rfu_pkg;

  // Operation codes of the op_select register.
  localparam logic [2:0] OP_ABS   = 3'd0;
  localparam logic [2:0] OP_CEIL  = 3'd1;
  localparam logic [2:0] OP_FLOOR = 3'd2;
  localparam logic [2:0] OP_RCP   = 3'd3;
  localparam logic [2:0] OP_NEG   = 3'd4;
  localparam logic [2:0] OP_ROUND = 3'd5;
  localparam logic [2:0] OP_SIGN  = 3'd6;

  // Pipeline shape: one front stage, the divider stages, one pack stage.
  localparam int DIV_STG      = 7;
  localparam int BITS_PER_STG = 4;
  localparam int QW           = DIV_STG * BITS_PER_STG;
  localparam int NUM_STG      = DIV_STG + 2;

  // Single-precision constants.
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] ONE_POS   = 32'h3F80_0000;
  localparam logic [31:0] ONE_NEG   = 32'hBF80_0000;
  localparam logic [31:0] NEAR_HALF = 32'h3EFF_FFFF;

  // State of one channel as it moves down the reciprocal pipeline.
  typedef struct packed {
    logic [23:0]        rem;
    logic [QW-1:0]      quo;
    logic [23:0]        mant;
    logic signed [10:0] ebase;
    logic               sign;
    logic [31:0]        simple;
    logic               use_simple;
  } stage_t;

  function automatic logic is_nan(logic [31:0] u);
    return u[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_neg(logic [31:0] u);
    return u[31] && !is_nan(u) && (u[30:0] != 31'd0);
  endfunction

  // Leading zero count of a 24-bit word.
  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] lz;
    lz = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  // Ceiling (up set) or floor of a single-precision value.
  function automatic logic [31:0] round_int(logic [31:0] u, logic up);
    logic [7:0]  e;
    logic [22:0] m;
    logic [31:0] mk;
    logic [31:0] r;
    e  = u[30:23];
    m  = 23'h7F_FFFF >> 5'(e - 8'd127);
    mk = {9'd0, m};
    if (e == 8'hFF) begin
      r = is_nan(u) ? (u | QUIET_BIT) : u;
    end else if (e >= 8'd150) begin
      r = u;
    end else if (e < 8'd127) begin
      if (u[30:0] == 31'd0) r = u;
      else if (up) r = u[31] ? SIGN_BIT : ONE_POS;
      else r = u[31] ? ONE_NEG : 32'd0;
    end else if ((u & mk) == 32'd0) begin
      r = u;
    end else begin
      r = (u[31] != up) ? (u + mk) : u;
      r = r & ~mk;
    end
    return r;
  endfunction

  // floor(x + 0.5) with the addition rounded to nearest-even; x is not NaN.
  function automatic logic [31:0] round_half(logic [31:0] u);
    logic [7:0]  e;
    logic [22:0] m;
    logic [31:0] mk;
    logic [31:0] hm;
    logic        h;
    logic        rst;
    logic        inc;
    logic [31:0] r;
    e   = u[30:23];
    m   = 23'h7F_FFFF >> 5'(e - 8'd127);
    mk  = {9'd0, m};
    hm  = mk ^ (mk >> 1);
    h   = |(u & hm);
    rst = |(u & (mk >> 1));
    inc = u[31] ? (h & rst) : h;
    if (e >= 8'd151) begin
      r = u;
    end else if (e == 8'd150) begin
      // The half is a tie at unit spacing: the sum goes to the even integer.
      r = u[31] ? (u & ~32'd1) : (u + {31'd0, u[0]});
    end else if (e >= 8'd127) begin
      r = inc ? (u + mk + 32'd1) : u;
      r = r & ~mk;
    end else if (e == 8'd126) begin
      if (!u[31]) r = ONE_POS;
      else r = (u[22:0] == 23'd0) ? 32'd0 : ONE_NEG;
    end else begin
      // Only the largest value below one half sums up to exactly one.
      r = (u == NEAR_HALF) ? ONE_POS : 32'd0;
    end
    return r;
  endfunction

  // Every operation but the general reciprocal.
  function automatic logic [31:0] simple_op(logic [2:0] op, logic [31:0] u);
    logic [31:0] r;
    unique case (op)
      OP_CEIL:  r = round_int(u, 1'b1);
      OP_FLOOR: r = round_int(u, 1'b0);
      OP_RCP: begin
        // NaN turns quiet, an infinity gives a signed zero, a zero an infinity.
        if (is_nan(u)) r = u | QUIET_BIT;
        else if (u[30:23] == 8'hFF) r = {u[31], 31'd0};
        else r = {u[31], 8'hFF, 23'd0};
      end
      OP_NEG:   r = u ^ SIGN_BIT;
      OP_ROUND: r = is_nan(u) ? (u | QUIET_BIT) : round_half(u);
      OP_SIGN:  r = is_neg(u) ? ONE_NEG : ONE_POS;
      default:  r = is_neg(u) ? {1'b0, u[30:0]} : u;
    endcase
    return r;
  endfunction

endpackage

// ===== design/rfu_front.sv =====
`timescale 1ns / 1ps

module rfu_front import rfu_pkg::*; (
  input  logic [2:0]  op_i,
  input  logic [31:0] data_i,
  output stage_t      front_o
);

  logic [7:0]  e;
  logic [4:0]  lz;
  logic [23:0] sub_m;

  assign e     = data_i[30:23];
  assign lz    = lzc24({1'b0, data_i[22:0]});
  assign sub_m = {1'b0, data_i[22:0]} << lz;

  // Normalize the divisor and pick the operations that need no division.
  always_comb begin
    front_o.rem    = 24'h40_0000;
    front_o.quo    = '0;
    front_o.sign   = data_i[31];
    front_o.simple = simple_op(op_i, data_i);
    front_o.use_simple = (op_i != OP_RCP) || (e == 8'hFF) || (data_i[30:0] == 31'd0);
    if (e != 8'd0) begin
      front_o.mant  = {1'b1, data_i[22:0]};
      front_o.ebase = 11'sd253 - $signed({3'd0, e});
    end else begin
      front_o.mant  = sub_m;
      front_o.ebase = 11'sd252 + $signed({6'd0, lz});
    end
  end

endmodule

// ===== design/rfu_div_step.sv =====
`timescale 1ns / 1ps

module rfu_div_step import rfu_pkg::*; (
  input  stage_t st_i,
  output stage_t st_o
);

  // BITS_PER_STG restoring division steps; the remainder stays below the divisor.
  always_comb begin
    logic [23:0]   r;
    logic [QW-1:0] q;
    logic [24:0]   t;
    r = st_i.rem;
    q = st_i.quo;
    for (int k = 0; k < BITS_PER_STG; k++) begin
      t = {r, 1'b0};
      if (t >= {1'b0, st_i.mant}) begin
        r = 24'(t - {1'b0, st_i.mant});
        q = {q[QW-2:0], 1'b1};
      end else begin
        r = t[23:0];
        q = {q[QW-2:0], 1'b0};
      end
    end
    st_o     = st_i;
    st_o.rem = r;
    st_o.quo = q;
  end

endmodule

// ===== design/rfu_pack.sv =====
`timescale 1ns / 1ps

module rfu_pack import rfu_pkg::*; (
  input  stage_t      st_i,
  output logic [31:0] res_o
);

  // Round the quotient to nearest-even and pack it, gradual underflow included.
  always_comb begin
    logic               big;
    logic [23:0]        sig;
    logic               g;
    logic               st;
    logic               sticky;
    logic signed [10:0] eb;
    logic [22:0]        fld;
    logic               g2;
    logic               st2;
    logic [30:0]        mag;
    sticky = st_i.rem != 24'd0;
    big    = st_i.quo[QW-1];
    sig    = big ? st_i.quo[QW-1:QW-24] : st_i.quo[QW-2:QW-25];
    g      = big ? st_i.quo[QW-25] : st_i.quo[QW-26];
    st     = big ? (|st_i.quo[QW-26:0]) | sticky : (|st_i.quo[QW-27:0]) | sticky;
    eb     = st_i.ebase + $signed({10'd0, big});
    fld    = '0;
    g2     = 1'b0;
    st2    = 1'b0;
    if (eb >= 11'sd255) begin
      mag = {8'hFF, 23'd0};
    end else if (eb >= 11'sd1) begin
      mag = {eb[7:0], sig[22:0]} + {30'd0, g & (st | sig[0])};
    end else begin
      if (eb == 11'sd0) begin
        fld = sig[23:1];
        g2  = sig[0];
        st2 = g | st;
      end else begin
        fld = {1'b0, sig[23:2]};
        g2  = sig[1];
        st2 = sig[0] | g | st;
      end
      mag = {8'd0, fld} + {30'd0, g2 & (st2 | fld[0])};
    end
    res_o = st_i.use_simple ? st_i.simple : {st_i.sign, mag};
  end

endmodule

// ===== design/rfu_chan.sv =====
`timescale 1ns / 1ps

module rfu_chan import rfu_pkg::*; (
  input  logic               clk_i,
  input  logic [NUM_STG-1:0] en_i,
  input  logic [2:0]         op_i,
  input  logic [31:0]        data_i,
  output logic [31:0]        data_o
);

  stage_t      front;
  stage_t      pipe_q [DIV_STG+1];
  stage_t      pipe_d [DIV_STG+1];
  logic [31:0] res_d;
  logic [31:0] res_q;

  rfu_front u_front (
    .op_i    (op_i),
    .data_i  (data_i),
    .front_o (front)
  );

  assign pipe_d[0] = front;

  // Divider stages, each fed by the register before it.
  for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
    rfu_div_step u_step (
      .st_i (pipe_q[k-1]),
      .st_o (pipe_d[k])
    );
  end

  rfu_pack u_pack (
    .st_i  (pipe_q[DIV_STG]),
    .res_o (res_d)
  );

  // Stage registers move only when their stage advances.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= DIV_STG; k++) begin
      if (en_i[k]) pipe_q[k] <= pipe_d[k];
    end
    if (en_i[NUM_STG-1]) res_q <= res_d;
  end

  assign data_o = res_q;

endmodule

// ===== design/rgb_float_unary_op_core.sv =====
`timescale 1ns / 1ps

// Applies the unary operation held in op_select to the red, green and blue
// single-precision values of each input word. The block is a nine-stage
// pipeline, and one word can be accepted in every cycle unless the pipeline
// is full and stalled. The depth is set by the reciprocal path, whose
// restoring divider produces four quotient bits per stage over seven stages,
// between one normalize stage and one round-and-pack stage. Each stage holds
// its word when the stage after it is full and stalled, so the input side
// keeps accepting until all nine stages are occupied. Write op_select only
// while no word is in flight.
module rgb_float_unary_op_core import rfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // red_out, green_out, blue_out
);

  logic [2:0]         op_q;
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] vld_d;
  logic [NUM_STG-1:0] adv;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_ABS;
    end else if (cfg_valid_i) begin
      op_q <= cfg_data_i;
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[NUM_STG-1] = !vld_q[NUM_STG-1] || m_axis_tready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = vld_q;
    if (adv[0]) vld_d[0] = s_axis_tvalid;
    for (int k = 1; k < NUM_STG; k++) begin
      if (adv[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[NUM_STG-1];

  // One pipeline per color channel.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    rfu_chan u_chan (
      .clk_i  (clk_i),
      .en_i   (adv),
      .op_i   (op_q),
      .data_i (s_axis_tdata[32*c +: 32]),
      .data_o (m_axis_tdata[32*c +: 32])
    );
  end

`ifndef NO_ASSERTIONS
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the full pipeline is stalled");

  a_ready_through : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("output ready did not reach the input side");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted word missing from the first stage");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rfu_pkg::*;

  // Selector seven has no code of its own in the package and behaves as abs.
  localparam logic [2:0] OP_ABS_ALT = 3'd7;
  localparam int RAND_PER_PHASE = 98;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = NUM_STG + 4;

  // Bit-exact model of the unary unit, for all three color channels.
  class rgb_scoreboard;
    logic [95:0] pending_q[$];
    logic [2:0] op;
    int errors;
    int words_in;
    int words_out;

    function new();
      op = OP_ABS;
      errors = 0;
      words_in = 0;
      words_out = 0;
    endfunction

    static function logic chan_nan(logic [31:0] u);
      return u[30:0] > 31'h7F80_0000;
    endfunction

    static function logic chan_neg(logic [31:0] u);
      return u[31] && !chan_nan(u) && (u[30:0] != 31'd0);
    endfunction

    // Widens a single to a double, exactly.
    static function logic [63:0] sgl_to_dbl(logic [31:0] u);
      int ex;
      logic [23:0] mm;
      if (u[30:0] == 31'd0) return {u[31], 63'd0};
      if (u[30:23] == 8'hFF) return {u[31], 11'h7FF, u[22:0], 29'd0};
      ex = (u[30:23] == 8'd0) ? -126 : int'(u[30:23]) - 127;
      mm = (u[30:23] == 8'd0) ? {1'b0, u[22:0]} : {1'b1, u[22:0]};
      while (!mm[23]) begin
        mm = mm << 1;
        ex--;
      end
      return {u[31], 11'(ex + 1023), mm[22:0], 29'd0};
    endfunction

    // Narrows a double to a single with round-to-nearest-even.
    static function logic [31:0] dbl_to_sgl(logic [63:0] d);
      int es;
      int sh;
      logic [63:0] mant;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mag;
      if (d[62:0] == 63'd0) return {d[63], 31'd0};
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
      es = int'(d[62:52]) - 1023 + 127;
      mant = {11'd0, 1'b1, d[51:0]};
      sh = 29 + ((es < 1) ? (1 - es) : 0);
      if (sh > 60) return {d[63], 31'd0};
      q = mant >> sh;
      rem = mant & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      mag = ((es >= 1) ? (64'(es - 1) << 23) : 64'd0) + q;
      if (mag >= 64'h7F80_0000) mag = 64'h7F80_0000;
      return {d[63], mag[30:0]};
    endfunction

    // Ceiling when up is set, floor otherwise.
    static function logic [31:0] to_integral(logic [31:0] u, logic up);
      logic [31:0] mk;
      logic [31:0] r;
      if (u[30:23] == 8'hFF) return chan_nan(u) ? (u | QUIET_BIT) : u;
      if (u[30:23] >= 8'd150) return u;
      if (u[30:23] < 8'd127) begin
        if (u[30:0] == 31'd0) return u;
        if (up) return u[31] ? SIGN_BIT : ONE_POS;
        return u[31] ? ONE_NEG : 32'd0;
      end
      mk = 32'h007F_FFFF >> (u[30:23] - 8'd127);
      if ((u & mk) == 32'd0) return u;
      r = (u[31] != up) ? (u + mk) : u;
      return r & ~mk;
    endfunction

    static function logic [31:0] chan_result(logic [2:0] sel, logic [31:0] u);
      real x;
      case (sel)
        OP_CEIL: return to_integral(u, 1'b1);
        OP_FLOOR: return to_integral(u, 1'b0);
        OP_RCP: begin
          if (chan_nan(u)) return u | QUIET_BIT;
          if (u[30:0] == 31'd0) return {u[31], 8'hFF, 23'd0};
          if (u[30:0] == 31'h7F80_0000) return {u[31], 31'd0};
          // Double rounding through a double is exact for a quotient.
          x = 1.0 / $bitstoreal(sgl_to_dbl(u));
          return dbl_to_sgl($realtobits(x));
        end
        OP_NEG: return u ^ SIGN_BIT;
        OP_ROUND: begin
          if (chan_nan(u)) return u | QUIET_BIT;
          x = $bitstoreal(sgl_to_dbl(u)) + 0.5;
          return to_integral(dbl_to_sgl($realtobits(x)), 1'b0);
        end
        OP_SIGN: return chan_neg(u) ? ONE_NEG : ONE_POS;
        default: return chan_neg(u) ? {1'b0, u[30:0]} : u;
      endcase
    endfunction

    function void note_input(logic [95:0] d);
      pending_q.push_back({chan_result(op, d[95:64]), chan_result(op, d[63:32]),
                           chan_result(op, d[31:0])});
      words_in++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH op %0d word %0d %s: got %08h want %08h",
               op, words_out, what, got, want);
      errors++;
    endtask

    task check_result(logic [95:0] d);
      logic [95:0] want;
      if (pending_q.size() == 0) begin
        report("unexpected word", d[31:0], 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (d[31:0] !== want[31:0]) report("red", d[31:0], want[31:0]);
        if (d[63:32] !== want[63:32]) report("green", d[63:32], want[63:32]);
        if (d[95:64] !== want[95:64]) report("blue", d[95:64], want[95:64]);
      end
      words_out++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [2:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [95:0] m_axis_tdata;

  rgb_scoreboard sb;
  int src_idle_pct;
  int dst_stall_pct;
  logic hold_req;
  int hold_left;
  int idle_cycles;

  rgb_float_unary_op_core u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end
  end

  // Monitor of both streams and the watchdog on lack of progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task send_word(logic [95:0] d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task write_op(logic [2:0] sel);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= sel;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.op = sel;
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random single with weight on the cases the operations treat specially.
  function logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = {v[31], ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00, 23'd0};
      1: v = {v[31], 8'hFF, v[22:1], 1'b1};
      2: v = {v[31], 8'h00, v[22:0]};
      3: v[30:23] = 8'(120 + $urandom_range(0, 32));
      4: begin
        v[30:23] = 8'(127 + $urandom_range(0, 23));
        v[22:0] = v[22:0] & ~(23'h7F_FFFF >> (v[30:23] - 8'd127));
      end
      5: begin
        v[30:23] = 8'(126 + $urandom_range(0, 25));
        v[22:0] = v[22:0] & ~(23'h3F_FFFF >> (v[30:23] - 8'd126));
      end
      6: v[30:23] = ($urandom_range(0, 1) != 0) ? 8'd253 : 8'd1;
      default: ;
    endcase
    return v;
  endfunction

  logic [31:0] directed [0:23] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0001, 32'h3F00_0000, 32'hBF00_0000, 32'h3EFF_FFFF,
    32'hBEFF_FFFF, 32'h3FC0_0000, 32'hC020_0000, 32'h4B00_0001,
    32'hCB00_0001, 32'h4B80_0000, 32'h3F80_0000, 32'hBF80_0000,
    32'h7F7F_FFFF, 32'h0080_0000, 32'h3E80_0000, 32'hBF40_0000
  };

  logic [2:0] op_list [0:7] = '{
    OP_ABS, OP_CEIL, OP_FLOOR, OP_RCP, OP_NEG, OP_ROUND, OP_SIGN, OP_ABS_ALT
  };

  initial begin
    int ph;
    int k;
    sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = OP_ABS;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < 8; ph++) begin
      // The first phase runs on the reset value of the selector.
      if (ph != 0) write_op(op_list[ph]);
      src_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 34 : 71) : 0;
      dst_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 34 : 71) : 0;
      for (k = 0; k < 8; k++) begin
        send_word({directed[(3 * k + 2) % 24], directed[(3 * k + 1) % 24],
                   directed[3 * k]});
      end
      // Fill the pipeline against a held-off receiver once.
      if (ph == 3) begin
        src_idle_pct = 0;
        hold_req <= 1'b1;
      end
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        send_word({pick_value(), pick_value(), pick_value()});
      end
      drain();
    end

    $display("Covered %0d words over all eight selector codes, with idle and stall mixes",
             sb.words_in);
    $display("and one long receiver hold-off; %0d results checked.", sb.words_out);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
